[rtl/i2cmr_pkg.sv]
// Package with shared types and constants for the single-byte I2C read master.
`default_nettype none
package i2cmr_pkg;

    localparam int PHASE_W = 6;
    localparam int TICK_W = 16;
    localparam int ADDR_W = 7;
    localparam int DATA_W = 8;
    localparam int SUB_W = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [PHASE_W-1:0] PHASE_IDLE = 6'd0;
    localparam logic [PHASE_W-1:0] PHASE_FIRST = 6'd1;
    localparam logic [PHASE_W-1:0] PHASE_LAST = 6'd60;

    localparam logic [ADDR_W-1:0] ADDR_RESET = 7'h5F;
    localparam logic [TICK_W-1:0] TICKS_RESET = 16'd400;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEVICE_ADDRESS = 1'b0,
        REG_PHASE_TICKS = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic scl;
        logic sda;
        logic samp_nack;
        logic samp_data;
        logic shift_send;
    } phase_ctl_t;

endpackage
`default_nettype wire

[rtl/i2cmr_if.sv]
// Valid/ready channel interfaces for input, result and configuration words.
`default_nettype none
interface i2cmr_in_if;
    logic valid;
    logic ready;
    logic start_read;
    logic sda_in;
    modport source (output valid, output start_read, output sda_in, input ready);
    modport sink (input valid, input start_read, input sda_in, output ready);
endinterface

interface i2cmr_out_if;
    logic valid;
    logic ready;
    logic scl_out;
    logic sda_out;
    logic busy_res;
    logic done_res;
    logic [i2cmr_pkg::DATA_W-1:0] data_byte;
    logic address_nack;
    modport source (output valid, output scl_out, output sda_out, output busy_res,
                    output done_res, output data_byte, output address_nack, input ready);
    modport sink (input valid, input scl_out, input sda_out, input busy_res,
                  input done_res, input data_byte, input address_nack, output ready);
endinterface

interface i2cmr_cfg_if;
    logic valid;
    logic ready;
    logic [i2cmr_pkg::CFG_IDX_W-1:0] index;
    logic [i2cmr_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[rtl/i2cmr_phase_dec.sv]
// Phase decoder giving pin levels and shift or sample strobes for one phase.
`default_nettype none
module i2cmr_phase_dec (
    input  wire logic [i2cmr_pkg::PHASE_W-1:0] phase,
    input  wire logic [i2cmr_pkg::SUB_W-1:0]   sub,
    input  wire logic                          send_msb,
    output i2cmr_pkg::phase_ctl_t               ctl
);

    // The phase number here is zero based; sub is that number modulo three.
    always_comb
    begin
        ctl = '0;
        if (phase < 6'd3)
        begin
            ctl.scl = (phase < 6'd2);
            ctl.sda = (phase == 6'd0);
        end
        else if (phase >= 6'd57)
        begin
            ctl.scl = (phase != 6'd57);
            ctl.sda = (phase == 6'd59);
        end
        else
        begin
            ctl.scl = (sub == 2'd1);
            if (phase < 6'd27)
            begin
                ctl.sda = send_msb;
                ctl.shift_send = (sub == 2'd2);
            end
            else
            begin
                ctl.sda = 1'b1;
                if (phase < 6'd54 && sub == 2'd1)
                begin
                    ctl.samp_nack = (phase < 6'd30);
                    ctl.samp_data = (phase >= 6'd30);
                end
            end
        end
    end

endmodule
`default_nettype wire

[rtl/i2c_master_single_byte_read_unit.sv]
// Top level of the single-byte I2C read master with its result register.
// The result word is registered and appears in the cycle after its input word is accepted.
// Throughput: one input word per cycle while the result side takes words.
// The result register lets the next word in while the current one is taken.
// Reset clears the phase sequencer to idle, lines released, and the result register empty.
`default_nettype none
module i2c_master_single_byte_read_unit (
    input  wire logic    clk,
    input  wire logic    rst_n,
    i2cmr_in_if.sink     in_ch,
    i2cmr_out_if.source  out_ch,
    i2cmr_cfg_if.sink    cfg_ch
);

    logic [i2cmr_pkg::ADDR_W-1:0]  addr_reg;
    logic [i2cmr_pkg::TICK_W-1:0]  ticks_reg;
    logic [i2cmr_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [i2cmr_pkg::TICK_W-1:0]  tick_reg, tick_next;
    logic [i2cmr_pkg::SUB_W-1:0]   sub_reg, sub_next;
    logic [i2cmr_pkg::DATA_W-1:0]  send_reg, send_next;
    logic [i2cmr_pkg::DATA_W-1:0]  recv_reg, recv_next;
    logic                          nack_reg, nack_next;
    logic                          scl_reg, scl_next;
    logic                          sda_reg, sda_next;
    logic                          busy_next, done_next;
    logic                          out_valid_reg;
    logic                          out_busy_reg, out_done_reg;

    logic                          in_fire;
    logic                          start_now;
    logic [i2cmr_pkg::PHASE_W-1:0] eff_phase;
    logic [i2cmr_pkg::TICK_W-1:0]  eff_tick;
    logic [i2cmr_pkg::SUB_W-1:0]   eff_sub;
    logic [i2cmr_pkg::DATA_W-1:0]  eff_send;
    logic [i2cmr_pkg::DATA_W-1:0]  eff_recv;
    logic                          eff_nack;
    logic [i2cmr_pkg::TICK_W-1:0]  len;
    logic [i2cmr_pkg::TICK_W:0]    tick_plus;
    logic                          last_tick;
    i2cmr_pkg::phase_ctl_t         ctl;

    assign in_fire = in_ch.valid && in_ch.ready;
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= i2cmr_pkg::ADDR_RESET;
            ticks_reg <= i2cmr_pkg::TICKS_RESET;
        end
        else if (cfg_ch.valid)
        begin
            case (i2cmr_pkg::cfg_reg_t'(cfg_ch.index))
                i2cmr_pkg::REG_DEVICE_ADDRESS: addr_reg <= cfg_ch.data[i2cmr_pkg::ADDR_W-1:0];
                i2cmr_pkg::REG_PHASE_TICKS:    ticks_reg <= cfg_ch.data;
                default: ;
            endcase
        end
    end

    assign start_now = (phase_reg == i2cmr_pkg::PHASE_IDLE) && in_ch.start_read;
    assign eff_phase = start_now ? i2cmr_pkg::PHASE_FIRST : phase_reg;
    assign eff_tick = start_now ? '0 : tick_reg;
    assign eff_sub = start_now ? '0 : sub_reg;
    assign eff_send = start_now ? {addr_reg, 1'b1} : send_reg;
    assign eff_recv = start_now ? '0 : recv_reg;
    assign eff_nack = start_now ? 1'b0 : nack_reg;

    assign len = (ticks_reg == '0) ? i2cmr_pkg::TICK_W'(1) : ticks_reg;
    assign tick_plus = {1'b0, eff_tick} + (i2cmr_pkg::TICK_W + 1)'(1);
    assign last_tick = tick_plus >= {1'b0, len};

    i2cmr_phase_dec u_phase_dec (
        .phase    (eff_phase - i2cmr_pkg::PHASE_W'(1)),
        .sub      (eff_sub),
        .send_msb (eff_send[i2cmr_pkg::DATA_W-1]),
        .ctl      (ctl)
    );

    always_comb
    begin
        phase_next = eff_phase;
        tick_next = eff_tick;
        sub_next = eff_sub;
        send_next = eff_send;
        recv_next = eff_recv;
        nack_next = eff_nack;
        scl_next = scl_reg;
        sda_next = sda_reg;
        busy_next = 1'b0;
        done_next = 1'b0;
        if (eff_phase != i2cmr_pkg::PHASE_IDLE)
        begin
            busy_next = 1'b1;
            scl_next = ctl.scl;
            sda_next = ctl.sda;
            if (last_tick)
            begin
                if (ctl.samp_nack)
                begin
                    nack_next = in_ch.sda_in;
                end
                if (ctl.samp_data)
                begin
                    recv_next = {eff_recv[i2cmr_pkg::DATA_W-2:0], in_ch.sda_in};
                end
                if (ctl.shift_send)
                begin
                    send_next = {eff_send[i2cmr_pkg::DATA_W-2:0], 1'b0};
                end
                tick_next = '0;
                sub_next = (eff_sub == 2'd2) ? '0 : eff_sub + 2'd1;
                if (eff_phase == i2cmr_pkg::PHASE_LAST)
                begin
                    phase_next = i2cmr_pkg::PHASE_IDLE;
                    done_next = 1'b1;
                end
                else
                begin
                    phase_next = eff_phase + i2cmr_pkg::PHASE_W'(1);
                end
            end
            else
            begin
                tick_next = tick_plus[i2cmr_pkg::TICK_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= i2cmr_pkg::PHASE_IDLE;
            tick_reg <= '0;
            sub_reg <= '0;
            send_reg <= '0;
            recv_reg <= '0;
            nack_reg <= 1'b0;
            scl_reg <= 1'b1;
            sda_reg <= 1'b1;
            out_busy_reg <= 1'b0;
            out_done_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            phase_reg <= phase_next;
            tick_reg <= tick_next;
            sub_reg <= sub_next;
            send_reg <= send_next;
            recv_reg <= recv_next;
            nack_reg <= nack_next;
            scl_reg <= scl_next;
            sda_reg <= sda_next;
            out_busy_reg <= busy_next;
            out_done_reg <= done_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.scl_out = scl_reg;
    assign out_ch.sda_out = sda_reg;
    assign out_ch.busy_res = out_busy_reg;
    assign out_ch.done_res = out_done_reg;
    assign out_ch.data_byte = recv_reg;
    assign out_ch.address_nack = nack_reg;

endmodule
`default_nettype wire

[rtl/i2cmr_checker.sv]
// Port-level checker for the single-byte I2C read master and its bind.
`default_nettype none
module i2cmr_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         in_valid,
    input wire logic                         in_ready,
    input wire logic                         out_valid,
    input wire logic                         out_ready,
    input wire logic                         busy_res,
    input wire logic                         done_res,
    input wire logic [i2cmr_pkg::DATA_W-1:0] data_byte,
    input wire logic                         address_nack
);

    // A finished transaction is still reported as busy on its last tick.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> busy_res)
        else $error("done word without busy");

    // Every accepted input word produces a result word on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted word produced no result");

    // With the result register empty, the input side must be open.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

    // A stalled result word keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(data_byte) && $stable(address_nack))
        else $error("stalled result word changed");

endmodule

bind i2c_master_single_byte_read_unit i2cmr_checker u_i2cmr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .busy_res     (out_ch.busy_res),
    .done_res     (out_ch.done_res),
    .data_byte    (out_ch.data_byte),
    .address_nack (out_ch.address_nack)
);
`default_nettype wire

[test/i2c_master_single_byte_read_unit_test.sv]
// Self-checking testbench for the single-byte I2C read master, with a cycle-exact bus predictor.
`timescale 1ns / 100ps
module i2c_master_single_byte_read_unit_test;

    typedef struct packed {
        logic start_read;
        logic sda_in;
    } tick_word_t;

    typedef struct packed {
        logic scl;
        logic sda;
        logic busy;
        logic done;
        logic [i2cmr_pkg::DATA_W-1:0] data;
        logic nack;
    } bus_word_t;

    typedef enum int {
        SDA_LOW,
        SDA_HIGH,
        SDA_RANDOM
    } sda_pattern_t;

    localparam int ADDR_FIRST = 3;
    localparam int DATA_FIRST = 27;
    localparam int NACK_LAST = 30;
    localparam int DATA_END = 54;
    localparam int STOP_FIRST = 57;
    localparam int HOLD_CYCLES = 80;

    logic clk = 1'b0;
    logic rst_n;

    i2cmr_in_if tick_ch ();
    i2cmr_out_if bus_ch ();
    i2cmr_cfg_if reg_ch ();

    i2c_master_single_byte_read_unit uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(tick_ch),
        .out_ch(bus_ch),
        .cfg_ch(reg_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Predicted state of the master, kept in step with every accepted word.
    logic [i2cmr_pkg::ADDR_W-1:0] m_addr = i2cmr_pkg::ADDR_RESET;
    logic [i2cmr_pkg::TICK_W-1:0] m_len = i2cmr_pkg::TICKS_RESET;
    logic [i2cmr_pkg::PHASE_W-1:0] m_phase = i2cmr_pkg::PHASE_IDLE;
    logic [i2cmr_pkg::TICK_W-1:0] m_count = '0;
    logic [i2cmr_pkg::DATA_W-1:0] m_send = '0;
    logic [i2cmr_pkg::DATA_W-1:0] m_recv = '0;
    logic m_nack = 1'b0;
    logic m_scl = 1'b1;
    logic m_sda = 1'b1;

    tick_word_t pending_ticks[$];
    bus_word_t expected_bus[$];

    int send_gap_pct = 0;
    int take_gap_pct = 0;
    int hold_asked = 0;
    int hold_served = 0;
    int hold_left = 0;
    bit tick_taken = 1'b0;

    int mismatch_count = 0;
    int words_sent = 0;
    int results_checked = 0;
    int reads_done = 0;
    int nack_reads = 0;
    int writes_done = 0;

    function automatic bus_word_t predict_bus(tick_word_t t);
        bus_word_t r;
        int p;
        int sub;
        int len;
        logic samp;
        r = '0;
        sub = 0;
        samp = 1'b0;
        if (m_phase == i2cmr_pkg::PHASE_IDLE && t.start_read)
        begin
            m_phase = i2cmr_pkg::PHASE_FIRST;
            m_count = '0;
            m_send = {m_addr, 1'b1};
            m_recv = '0;
            m_nack = 1'b0;
        end
        if (m_phase != i2cmr_pkg::PHASE_IDLE)
        begin
            p = int'(m_phase) - 1;
            len = (m_len == 0) ? 1 : int'(m_len);
            r.busy = 1'b1;
            if (p < ADDR_FIRST)
            begin
                m_scl = (p < 2);
                m_sda = (p == 0);
            end
            else if (p >= STOP_FIRST)
            begin
                m_scl = (p != STOP_FIRST);
                m_sda = (p == STOP_FIRST + 2);
            end
            else
            begin
                sub = (p - ADDR_FIRST) % 3;
                m_scl = (sub == 1);
                if (p < DATA_FIRST)
                    m_sda = m_send[i2cmr_pkg::DATA_W-1];
                else
                begin
                    m_sda = 1'b1;
                    samp = (p < DATA_END && sub == 1);
                end
            end
            if (int'(m_count) + 1 >= len)
            begin
                if (samp)
                begin
                    if (p < NACK_LAST)
                        m_nack = t.sda_in;
                    else
                        m_recv = {m_recv[i2cmr_pkg::DATA_W-2:0], t.sda_in};
                end
                if (p >= ADDR_FIRST && p < DATA_FIRST && sub == 2)
                    m_send = m_send << 1;
                m_count = '0;
                if (m_phase >= i2cmr_pkg::PHASE_LAST)
                begin
                    m_phase = i2cmr_pkg::PHASE_IDLE;
                    r.done = 1'b1;
                end
                else
                    m_phase = m_phase + 1'b1;
            end
            else
                m_count = m_count + 1'b1;
        end
        r.scl = m_scl;
        r.sda = m_sda;
        r.data = m_recv;
        r.nack = m_nack;
        return r;
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        mismatch_count++;
        $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    // Monitor: checks result words, follows register writes and predicts each accepted word.
    always @(posedge clk)
    begin
        bus_word_t got;
        bus_word_t want;
        tick_word_t t;
        if (!rst_n)
            tick_taken = 1'b0;
        else
        begin
            if (bus_ch.valid && bus_ch.ready)
            begin
                got.scl = bus_ch.scl_out;
                got.sda = bus_ch.sda_out;
                got.busy = bus_ch.busy_res;
                got.done = bus_ch.done_res;
                got.data = bus_ch.data_byte;
                got.nack = bus_ch.address_nack;
                if (expected_bus.size() == 0)
                    flag_mismatch("word with none expected", 1, 0);
                else
                begin
                    want = expected_bus.pop_front();
                    if (got.scl !== want.scl)
                        flag_mismatch("scl_out", got.scl, want.scl);
                    if (got.sda !== want.sda)
                        flag_mismatch("sda_out", got.sda, want.sda);
                    if (got.busy !== want.busy)
                        flag_mismatch("busy_res", got.busy, want.busy);
                    if (got.done !== want.done)
                        flag_mismatch("done_res", got.done, want.done);
                    if (got.data !== want.data)
                        flag_mismatch("data_byte", got.data, want.data);
                    if (got.nack !== want.nack)
                        flag_mismatch("address_nack", got.nack, want.nack);
                    results_checked++;
                    if (want.done)
                    begin
                        reads_done++;
                        if (want.nack)
                            nack_reads++;
                    end
                end
            end
            if (reg_ch.valid && reg_ch.ready)
            begin
                case (i2cmr_pkg::cfg_reg_t'(reg_ch.index))
                    i2cmr_pkg::REG_DEVICE_ADDRESS:
                        m_addr = reg_ch.data[i2cmr_pkg::ADDR_W-1:0];
                    i2cmr_pkg::REG_PHASE_TICKS:
                        m_len = reg_ch.data[i2cmr_pkg::TICK_W-1:0];
                    default: ;
                endcase
            end
            if (tick_ch.valid && tick_ch.ready)
            begin
                t.start_read = tick_ch.start_read;
                t.sda_in = tick_ch.sda_in;
                expected_bus.push_back(predict_bus(t));
                words_sent++;
            end
            tick_taken = tick_ch.valid && tick_ch.ready;
        end
    end

    // Driver: offers pending words, holding each until it is taken.
    always @(negedge clk)
    begin
        tick_word_t w;
        if (rst_n && !(tick_ch.valid && !tick_taken))
        begin
            if (pending_ticks.size() > 0 && $urandom_range(0, 99) >= send_gap_pct)
            begin
                w = pending_ticks.pop_front();
                tick_ch.valid <= 1'b1;
                tick_ch.start_read <= w.start_read;
                tick_ch.sda_in <= w.sda_in;
            end
            else
                tick_ch.valid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_asked != hold_served)
        begin
            hold_served = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            bus_ch.ready <= 1'b0;
        end
        else
            bus_ch.ready <= ($urandom_range(0, 99) >= take_gap_pct);
    end

    task automatic queue_ticks(int count, int start_pct, sda_pattern_t pat);
        tick_word_t w;
        repeat (count)
        begin
            w.start_read = ($urandom_range(0, 99) < start_pct);
            case (pat)
                SDA_LOW: w.sda_in = 1'b0;
                SDA_HIGH: w.sda_in = 1'b1;
                default: w.sda_in = $urandom_range(0, 1);
            endcase
            pending_ticks.push_back(w);
        end
    endtask

    task automatic queue_read(int len, int busy_start_pct, sda_pattern_t pat);
        queue_ticks(1, 100, pat);
        queue_ticks(int'(i2cmr_pkg::PHASE_LAST) * len - 1, busy_start_pct, pat);
    endtask

    task automatic wait_drained();
        while (pending_ticks.size() > 0 || tick_ch.valid || expected_bus.size() > 0)
            @(negedge clk);
    endtask

    task automatic write_setting(logic [i2cmr_pkg::ADDR_W-1:0] addr,
                                 logic [i2cmr_pkg::TICK_W-1:0] len);
        reg_ch.index <= i2cmr_pkg::REG_DEVICE_ADDRESS;
        reg_ch.data <= i2cmr_pkg::CFG_DATA_W'(addr);
        reg_ch.valid <= 1'b1;
        do @(posedge clk); while (!reg_ch.ready);
        @(negedge clk);
        reg_ch.index <= i2cmr_pkg::REG_PHASE_TICKS;
        reg_ch.data <= len;
        do @(posedge clk); while (!reg_ch.ready);
        @(negedge clk);
        reg_ch.valid <= 1'b0;
        writes_done += 2;
    endtask

    initial
    begin
        #1_000_000;
        $display("** i2c_master_single_byte_read_unit: FAILED **");
        $finish;
    end

    initial
    begin
        int mode;
        int s;
        int eff;
        logic [i2cmr_pkg::ADDR_W-1:0] addr;
        logic [i2cmr_pkg::TICK_W-1:0] len;
        tick_ch.valid = 1'b0;
        tick_ch.start_read = 1'b0;
        tick_ch.sda_in = 1'b0;
        bus_ch.ready = 1'b0;
        reg_ch.valid = 1'b0;
        reg_ch.index = i2cmr_pkg::REG_DEVICE_ADDRESS;
        reg_ch.data = '0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings, starts while busy, then a zero phase length written mid-phase.
        queue_ticks(2, 0, SDA_LOW);
        queue_ticks(1, 100, SDA_LOW);
        queue_ticks(4, 100, SDA_HIGH);
        wait_drained();
        write_setting(i2cmr_pkg::ADDR_RESET, '0);
        queue_ticks(int'(i2cmr_pkg::PHASE_LAST) - 1, 0, SDA_LOW);
        queue_ticks(2, 0, SDA_HIGH);
        wait_drained();

        // Top address, no acknowledge, all-ones byte, and a start on the done word.
        write_setting('1, 16'd1);
        queue_ticks(1, 100, SDA_HIGH);
        queue_ticks(int'(i2cmr_pkg::PHASE_LAST) - 2, 0, SDA_HIGH);
        queue_ticks(1, 100, SDA_HIGH);
        queue_ticks(1, 0, SDA_LOW);

        for (mode = 0; mode < 3; mode++)
        begin
            send_gap_pct = (mode == 0) ? 19 : (mode == 1) ? 76 : 0;
            take_gap_pct = (mode == 0) ? 76 : (mode == 1) ? 19 : 0;
            for (s = 0; s < 3; s++)
            begin
                wait_drained();
                if (mode == 0 && s == 0)
                    addr = '0;
                else if (mode == 1 && s == 0)
                    addr = '1;
                else
                    addr = $urandom_range(0, 127);
                len = (mode == 1 && s == 1) ? '1 : i2cmr_pkg::TICK_W'($urandom_range(0, 3));
                write_setting(addr, len);
                if (mode == 2 && s == 0)
                    hold_asked++;
                if (len == '1)
                begin
                    // Longest phase, cut short by a smaller length written mid-phase.
                    queue_ticks(1, 100, SDA_RANDOM);
                    queue_ticks($urandom_range(4, 20), 25, SDA_RANDOM);
                    wait_drained();
                    eff = $urandom_range(1, 3);
                    write_setting(addr, i2cmr_pkg::TICK_W'(eff));
                    queue_ticks(int'(i2cmr_pkg::PHASE_LAST) * eff, 15, SDA_RANDOM);
                end
                else
                begin
                    eff = (len == 0) ? 1 : int'(len);
                    queue_read(eff, 15, SDA_RANDOM);
                end
                queue_ticks($urandom_range(0, 8), 0, SDA_RANDOM);
            end
        end

        wait_drained();
        repeat (5) @(posedge clk);
        if (expected_bus.size() > 0)
            flag_mismatch("words left unanswered", expected_bus.size(), 0);
        $display("Run covered %0d tick words and %0d checked results over %0d register writes.",
                 words_sent, results_checked, writes_done);
        $display("%0d reads completed, %0d of them without an address acknowledge; %0d mismatches.",
                 reads_done, nack_reads, mismatch_count);
        if (mismatch_count == 0)
            $display("** i2c_master_single_byte_read_unit: PASSED **");
        else
            $display("** i2c_master_single_byte_read_unit: FAILED **");
        $finish;
    end

endmodule
